// ===== rtl/csba_pkg.sv =====
`timescale 1ns / 1ps

package csba_pkg;

  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [19:0] size_bytes;
    logic [31:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] run_address;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_REL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic prep;
    logic scan_step;
    logic release_run;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== rtl/csba_ctrl.sv =====
`timescale 1ns / 1ps

module csba_ctrl
  import csba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.is_release ? ST_REL : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit || stat.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_REL: begin
        cmd.release_run = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result word overwritten while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ===== rtl/csba_dpath.sv =====
`timescale 1ns / 1ps

module csba_dpath
  import csba_pkg::*;
#(
  parameter int SLOT_COUNT  = 64,
  parameter int BLOCK_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  input  in_word_t    in_word,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output dp_stat_t    stat,
  output out_word_t   out_word
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);
  localparam int NW = 21 - BLOCK_SHIFT;
  localparam int CW = (NW > LW) ? NW : LW;
  localparam int HW = 32 - BLOCK_SHIFT;

  logic [SLOT_COUNT-1:0] map_r;
  logic [SLOT_COUNT-1:0] map_nxt;
  logic [31:0]           base_r;
  in_word_t              req_r;
  logic [NW-1:0]         n_r;
  logic [31:0]           off_r;
  logic [SW-1:0]         idx_r;
  logic [SW-1:0]         run_start_r;
  logic [LW-1:0]         run_len_r;
  logic                  found_r;
  out_word_t             out_word_r;

  logic                  slot_free;
  logic [SW-1:0]         start_eff;
  logic [LW-1:0]         len1;
  logic                  hit;
  logic [HW-1:0]         rel_slot_full;
  logic                  rel_in_range;
  logic [SW-1:0]         rel_start;
  logic [SW-1:0]         rel_diff [SLOT_COUNT];
  logic [NW-1:0]         n_calc;

  assign n_calc = NW'(req_r.size_bytes >> BLOCK_SHIFT)
                + NW'(req_r.size_bytes[BLOCK_SHIFT-1:0] != '0);

  assign slot_free = !map_r[idx_r];
  assign start_eff = (run_len_r == '0) ? idx_r : run_start_r;
  assign len1      = run_len_r + LW'(1);
  assign hit       = slot_free && ((n_r == '0) || (CW'(len1) == CW'(n_r)));

  assign rel_slot_full = off_r[31:BLOCK_SHIFT];
  assign rel_in_range  = rel_slot_full < HW'(SLOT_COUNT);
  assign rel_start     = rel_slot_full[SW-1:0];

  always_comb begin
    map_nxt = map_r;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      rel_diff[k] = SW'(k) - rel_start;
      if (cmd.scan_step && hit && (n_r != '0)
          && (SW'(k) >= start_eff) && (SW'(k) <= idx_r)) begin
        map_nxt[k] = 1'b1;
      end
      if (cmd.release_run && rel_in_range && (SW'(k) >= rel_start)
          && (CW'(rel_diff[k]) < CW'(n_r))) begin
        map_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= '0;
      base_r <= '0;
    end else begin
      map_r <= map_nxt;
      if (cfg_we) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
    if (cmd.prep) begin
      n_r       <= n_calc;
      off_r     <= req_r.release_address - base_r;
      idx_r     <= '0;
      run_len_r <= '0;
      found_r   <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + SW'(1);
      if (hit) begin
        found_r     <= 1'b1;
        run_start_r <= start_eff;
      end else if (slot_free) begin
        run_len_r   <= len1;
        run_start_r <= start_eff;
      end else begin
        run_len_r <= '0;
      end
    end
    if (cmd.load_out) begin
      if (req_r.func == FUNC_RELEASE) begin
        out_word_r.granted     <= 1'b1;
        out_word_r.run_address <= '0;
      end else begin
        out_word_r.granted     <= found_r;
        out_word_r.run_address <= found_r
          ? base_r + (32'(run_start_r) << BLOCK_SHIFT) : 32'd0;
      end
    end
  end

  assign stat.is_release = (req_r.func == FUNC_RELEASE);
  assign stat.scan_hit   = hit;
  assign stat.scan_last  = (idx_r == SW'(SLOT_COUNT - 1));
  assign out_word        = out_word_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_run |=> ((map_r & ~$past(map_r)) == '0))
    else $error("release set a used bit");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |=> ((~map_r & $past(map_r)) == '0))
    else $error("scan cleared a used bit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && hit && (n_r != '0)) |=> map_r[$past(start_eff)])
    else $error("granted run start not marked");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && hit) |-> !map_r[start_eff])
    else $error("run starts on a used slot");

endmodule

// ===== rtl/contiguous_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// First-fit allocator over SLOT_COUNT blocks of 2**BLOCK_SHIFT bytes each.
// Input channel (in_valid / in_stall / in_word): one request word, either
// reserve (size in bytes) or release (address and size in bytes).
// Output channel (out_valid / out_stall / out_word): one result word per
// request: granted flag and run address (0 on failure or release).
// Config channel (cfg_valid / cfg_ready / cfg_data): base address of block
// zero; always ready, write only while the allocator is idle.
// A release passes from accept through the prepare, release and done steps;
// a reserve goes through the prepare step, then a slot-by-slot scan of the
// used-bit map, one slot per cycle, stopping at the first run that fits or
// at the last slot, then the done step. The next request is accepted the
// cycle after a result is loaded.
// One request is in work at a time; in_stall is high until its result is
// in the output register. The output register lets the next request be
// accepted while a result still waits; a request then finishes its work and
// holds in its last step until the stalled result is taken.
// Reset (rst_n low, synchronous) frees every slot, clears the base address
// and drops any pending result.
module contiguous_slot_bitmap_allocator
  import csba_pkg::*;
#(
  parameter int SLOT_COUNT  = 64,
  parameter int BLOCK_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  csba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  csba_dpath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule
